[hdl/mpsm_pkg.sv]
// mpsm_pkg: shared types and constants of the Morris-Pratt stream matcher
// holds the request and response beat structs, the sequencer states and defaults
// no dependencies
package mpsm_pkg;

   // default sizes
   localparam int MPSM_MAX_PATTERN   = 64;
   localparam int MPSM_SYMBOL_BITS   = 8;
   localparam int MPSM_POSITION_BITS = 16;

   // function codes of a request beat
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TEXT = 1'b1;

   // request beat
   typedef struct packed {
      logic       func;
      logic [7:0] symbol;
      logic       first;
   } req_type;

   // response beat
   typedef struct packed {
      logic        match;
      logic [15:0] match_start;
      logic        overflow;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEXT_WALK,
      ST_TEXT_LINK,
      ST_BUILD_WALK,
      ST_OUT
   } state_type;

endpackage

[hdl/morris_pratt_stream_matcher.sv]
// morris_pratt_stream_matcher: streaming Morris-Pratt matcher with incremental link build
// holds the sequencer, the pattern memory and the failure-link memory
// depends on mpsm_pkg

// Each request beat yields exactly one response beat. A load beat (func 0) stores one
// pattern symbol and extends the failure-link table; it finishes on acceptance when the
// store is full or the build cursor has no link, else it walks the link chain with one
// pattern entry compared per step. A text beat finishes on acceptance when the pattern
// is empty, else it walks failure links with one entry compared per step, plus a link
// step when a full match fetches the link of the whole pattern; the walk amortizes to
// at most two compares per text symbol. Each walk step reads the pattern memory and the
// link memory, both synchronous with a registered read, and the next address is the
// link just read. A finished response goes to an output register, and a second one
// waits in a pending register, so the block only stalls when both are full. The
// memories need no clearing pass: only entries already written are used.
module morris_pratt_stream_matcher
   import mpsm_pkg::*;
#(
   parameter int MAX_PATTERN   = MPSM_MAX_PATTERN,
   parameter int SYMBOL_BITS   = MPSM_SYMBOL_BITS,
   parameter int POSITION_BITS = MPSM_POSITION_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LEN_BITS  = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_PATTERN);

   // control registers
   state_type                 state_ff, state_in;
   logic [LEN_BITS-1:0]       length_ff, length_in;
   logic [LEN_BITS-1:0]       bc_ff, bc_in;
   logic                      bc_none_ff, bc_none_in;
   logic [LEN_BITS-1:0]       mc_ff, mc_in;
   logic [POSITION_BITS-1:0]  tp_ff, tp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [LEN_BITS-1:0]       cur_ff, cur_in;
   logic [SYMBOL_BITS-1:0]    sym_ff, sym_in;
   rsp_type                   rsp_data_ff, pend_ff;

   // memories
   logic [SYMBOL_BITS-1:0]    store_mem [MAX_PATTERN];
   logic [LEN_BITS-1:0]       link_mem  [MAX_PATTERN+1];
   logic [SYMBOL_BITS-1:0]    store_rd_ff;
   logic [LEN_BITS-1:0]       link_rd_ff;

   // memory ports
   logic                      st_we;
   logic [ADDR_BITS-1:0]      st_wr_addr, st_rd_addr;
   logic [SYMBOL_BITS-1:0]    st_wr_data;
   logic                      fl_we;
   logic [LEN_BITS-1:0]       fl_wr_addr, fl_rd_addr, fl_wr_data;

   // shared conditions
   logic                      accept, out_free, finish, rsp_load, pend_load;
   logic                      full, bc_none_eff, hit, cur_zero, j_full;
   logic [LEN_BITS-1:0]       len_eff, j_hit;
   logic [SYMBOL_BITS-1:0]    sym_req;
   rsp_type                   res;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid & req_ready;
   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign sym_req     = SYMBOL_BITS'(req_data.symbol);
   assign len_eff     = req_data.first ? '0 : length_ff;
   assign full        = (len_eff == LEN_MAX);
   assign bc_none_eff = req_data.first | bc_none_ff;
   assign hit         = (store_rd_ff == sym_ff);
   assign cur_zero    = (cur_ff == '0);
   assign j_hit       = LEN_BITS'(cur_ff + 1'b1);
   assign j_full      = (j_hit == length_ff);

   // one beat's work ends this cycle
   always_comb begin
      finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_TEXT) finish = (length_ff == '0);
               else                            finish = full | bc_none_eff;
            end
         end
         ST_TEXT_WALK:  finish = hit ? ~j_full : cur_zero;
         ST_TEXT_LINK:  finish = 1'b1;
         ST_BUILD_WALK: finish = hit | cur_zero;
         default:       finish = 1'b0;
      endcase
   end

   assign rsp_load  = (finish | (state_ff == ST_OUT)) & out_free;
   assign pend_load = finish & ~out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      if (finish) begin
         state_in = out_free ? ST_IDLE : ST_OUT;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_in = (req_data.func == FUNC_TEXT) ? ST_TEXT_WALK : ST_BUILD_WALK;
               end
            end
            ST_TEXT_WALK: state_in = hit ? ST_TEXT_LINK : ST_TEXT_WALK;
            ST_BUILD_WALK: state_in = ST_BUILD_WALK;
            ST_OUT: state_in = out_free ? ST_IDLE : ST_OUT;
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // datapath and memory control
   always_comb begin
      length_in  = length_ff;
      bc_in      = bc_ff;
      bc_none_in = bc_none_ff;
      mc_in      = mc_ff;
      tp_in      = tp_ff;
      cur_in     = cur_ff;
      sym_in     = sym_ff;
      st_we      = 1'b0;
      st_wr_addr = len_eff[ADDR_BITS-1:0];
      st_wr_data = sym_req;
      st_rd_addr = cur_ff[ADDR_BITS-1:0];
      fl_we      = 1'b0;
      fl_wr_addr = LEN_BITS'(length_ff + 1'b1);
      fl_wr_data = '0;
      fl_rd_addr = cur_ff;
      res        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sym_in = sym_req;
               if (req_data.func == FUNC_TEXT) begin
                  // text beat: position of this symbol is tp, advance now
                  tp_in = req_data.first ? POSITION_BITS'(1) : POSITION_BITS'(tp_ff + 1'b1);
                  if (length_ff == '0) begin
                     mc_in = '0;
                  end else begin
                     cur_in     = req_data.first ? '0 : mc_ff;
                     st_rd_addr = cur_in[ADDR_BITS-1:0];
                     fl_rd_addr = cur_in;
                  end
               end else begin
                  // load beat: pattern restart clears the load and match state
                  if (req_data.first) begin
                     length_in  = '0;
                     bc_none_in = 1'b1;
                     mc_in      = '0;
                  end
                  if (full) begin
                     res.overflow = 1'b1;
                  end else begin
                     st_we     = 1'b1;
                     length_in = len_eff;
                     if (bc_none_eff) begin
                        // no link to walk: new link is zero
                        fl_we      = 1'b1;
                        fl_wr_addr = LEN_BITS'(len_eff + 1'b1);
                        fl_wr_data = '0;
                        length_in  = LEN_BITS'(len_eff + 1'b1);
                        bc_in      = '0;
                        bc_none_in = 1'b0;
                     end else begin
                        cur_in     = bc_ff;
                        st_rd_addr = bc_ff[ADDR_BITS-1:0];
                        fl_rd_addr = bc_ff;
                     end
                  end
               end
            end
         end
         ST_TEXT_WALK: begin
            if (hit) begin
               if (j_full) begin
                  // full match: fetch the link of the whole pattern
                  fl_rd_addr = length_ff;
               end else begin
                  mc_in = j_hit;
               end
            end else if (cur_zero) begin
               mc_in = '0;
            end else begin
               cur_in     = link_rd_ff;
               st_rd_addr = link_rd_ff[ADDR_BITS-1:0];
               fl_rd_addr = link_rd_ff;
            end
         end
         ST_TEXT_LINK: begin
            mc_in           = link_rd_ff;
            res.match       = 1'b1;
            res.match_start = 16'(POSITION_BITS'(tp_ff - POSITION_BITS'(length_ff)));
         end
         ST_BUILD_WALK: begin
            if (hit | cur_zero) begin
               fl_we      = 1'b1;
               fl_wr_data = hit ? j_hit : '0;
               length_in  = LEN_BITS'(length_ff + 1'b1);
               bc_in      = fl_wr_data;
               bc_none_in = 1'b0;
            end else begin
               cur_in     = link_rd_ff;
               st_rd_addr = link_rd_ff[ADDR_BITS-1:0];
               fl_rd_addr = link_rd_ff;
            end
         end
         ST_OUT: begin
            res = pend_ff;
         end
         default: begin
            res = '0;
         end
      endcase
   end

   // output register handshake
   always_comb begin
      if (rsp_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         bc_ff        <= '0;
         bc_none_ff   <= 1'b1;
         mc_ff        <= '0;
         tp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         bc_ff        <= bc_in;
         bc_none_ff   <= bc_none_in;
         mc_ff        <= mc_in;
         tp_ff        <= tp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      sym_ff <= sym_in;
      if (rsp_load)  rsp_data_ff <= res;
      if (pend_load) pend_ff     <= res;
   end

   // pattern memory
   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_wr_addr] <= st_wr_data;
      store_rd_ff <= store_mem[st_rd_addr];
   end

   // failure-link memory
   always_ff @(posedge clock) begin
      if (fl_we) link_mem[fl_wr_addr] <= fl_wr_data;
      link_rd_ff <= link_mem[fl_rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_walk_in_pattern: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEXT_WALK || state_ff == ST_BUILD_WALK) |-> (cur_ff < length_ff))
      else $error("walk cursor outside the pattern");

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_MAX)
      else $error("pattern length past capacity");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (length_ff != '0) |-> (mc_ff < length_ff))
      else $error("match cursor outside the pattern");

   a_pend_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> rsp_valid_ff)
      else $error("pending beat with empty output register");

   a_match_xor_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.match && rsp_data_ff.overflow))
      else $error("response flags both match and overflow");

endmodule

[verif/mpsm_match_checker.sv]
// mpsm_match_checker: watches both beat channels of the Morris-Pratt stream matcher
// predicts every response beat and compares it field by field, counts failures
// depends on mpsm_pkg
module mpsm_match_checker
   import mpsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAT_MAX = MPSM_MAX_PATTERN;

   // predicted matcher state
   logic [7:0]  pat_sym [PAT_MAX];
   int          link_tab [PAT_MAX + 1];
   int          pat_len;
   int          build_pos;
   int          scan_pos;
   logic [15:0] text_pos;

   // responses owed by the block, oldest first
   rsp_type     rsp_due [$];
   int          errors;

   task automatic clear_matcher_state();
      for (int i = 0; i < PAT_MAX; i++) pat_sym[i] = '0;
      for (int i = 0; i <= PAT_MAX; i++) link_tab[i] = 0;
      link_tab[0] = -1;
      pat_len     = 0;
      build_pos   = -1;
      scan_pos    = 0;
      text_pos    = '0;
   endtask

   // advance the predicted state by one request beat and return its response
   function automatic rsp_type predict_match(input req_type beat);
      rsp_type r;
      int      j;
      r = '0;
      if (beat.func == FUNC_LOAD) begin
         if (beat.first) begin
            pat_len     = 0;
            build_pos   = -1;
            link_tab[0] = -1;
            scan_pos    = 0;
         end
         if (pat_len >= PAT_MAX) begin
            r.overflow = 1'b1;
         end else begin
            pat_sym[pat_len] = beat.symbol;
            // extend the link table, comparing only against earlier symbols
            j = build_pos;
            while (j >= 0 && j < pat_len && pat_sym[j] != beat.symbol) j = link_tab[j];
            if (j >= pat_len) j = -1;
            j++;
            link_tab[pat_len + 1] = j;
            build_pos = j;
            pat_len++;
         end
      end else begin
         if (beat.first) begin
            text_pos = '0;
            scan_pos = 0;
         end
         if (pat_len > 0) begin
            // walk failure links until the symbol fits or no link is left
            j = scan_pos;
            while (j >= 0 && j < pat_len && pat_sym[j] != beat.symbol) j = link_tab[j];
            if (j >= pat_len) j = -1;
            j++;
            // full match: report start, fall back so overlaps are found
            if (j >= pat_len) begin
               r.match       = 1'b1;
               r.match_start = text_pos - 16'(pat_len) + 16'd1;
               j             = link_tab[pat_len];
            end
            scan_pos = j;
         end else begin
            scan_pos = 0;
         end
         text_pos++;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // response side first: a beat never leaves in the cycle it arrives
   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         clear_matcher_state();
         rsp_due.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               $display("%0t ns: response beat with none due, expected nothing, got %0d/%0d/%0d",
                        $time, rsp_data.match, rsp_data.match_start, rsp_data.overflow);
               errors++;
            end else begin
               want = rsp_due.pop_front();
               check_field("match", want.match, rsp_data.match);
               check_field("match_start", want.match_start, rsp_data.match_start);
               check_field("overflow", want.overflow, rsp_data.overflow);
            end
         end
         if (req_valid && req_ready) begin
            fresh   = predict_match(req_data);
            rsp_due = {rsp_due, fresh};
         end
      end
      error_count <= errors;
      results_due <= rsp_due.size();
   end

endmodule

[verif/tb_morris_pratt_stream_matcher.sv]
// tb_morris_pratt_stream_matcher: stimulus and verdict for the Morris-Pratt stream matcher
// drives pattern and text beats, toggles backpressure, checking lives in mpsm_match_checker
// depends on mpsm_pkg, morris_pratt_stream_matcher and mpsm_match_checker
module tb_morris_pratt_stream_matcher;
   timeunit 1ns;
   timeprecision 1ps;
   import mpsm_pkg::*;

   // the cycle limit leaves a wide margin over a full run
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int PHASE_BEATS   = 400;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      error_count;
   int      results_due;
   int      cycles;
   int      beats_sent;
   int      tx_idle_pct;
   int      rx_idle_pct;
   int      hold_count  = 0;
   int      holds_taken = 0;

   logic [7:0] alphabet [4];
   int         alphabet_size;

   morris_pratt_stream_matcher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mpsm_match_checker match_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .results_due (results_due)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off for each one requested
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (holds_taken < hold_count) begin
            holds_taken++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // offer one beat, with random gaps ahead of it, and wait for it to be taken
   task automatic send_beat(input logic fn, input logic [7:0] sym, input logic restart);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {fn, sym, restart};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // stop offering until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // mostly symbols of a tiny alphabet so that matches are frequent
   function automatic logic [7:0] pick_symbol();
      if ($urandom_range(19) == 0) return 8'($urandom_range(255));
      return alphabet[$urandom_range(alphabet_size - 1)];
   endfunction

   // one pattern load followed by a text stream over the same alphabet
   task automatic run_sequence();
      int pat_n;
      int text_n;
      alphabet_size = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 4);
      for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(255));
      // a few long patterns run into the full store
      pat_n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int i = 0; i < pat_n; i++) begin
         if (i == 0) send_beat(FUNC_LOAD, pick_symbol(), $urandom_range(9) != 0);
         else send_beat(FUNC_LOAD, pick_symbol(), $urandom_range(29) == 0);
      end
      if ($urandom_range(19) == 0) wait_drained();
      text_n = $urandom_range(8, 40);
      for (int i = 0; i < text_n; i++) begin
         if (i == 0) send_beat(FUNC_TEXT, pick_symbol(), 1'($urandom_range(1)));
         else send_beat(FUNC_TEXT, pick_symbol(), $urandom_range(39) == 0);
      end
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input logic long_hold);
      int target;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target      = beats_sent + PHASE_BEATS;
      if (long_hold) hold_count++;
      while (beats_sent < target) run_sequence();
      wait_drained();
   endtask

   // main stimulus and verdict
   initial begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty pattern: text never matches
      send_beat(FUNC_TEXT, 8'h00, 1'b0);
      send_beat(FUNC_TEXT, 8'hFF, 1'b1);
      send_beat(FUNC_TEXT, 8'h80, 1'b0);
      // pattern appended straight from reset, extreme symbols
      send_beat(FUNC_LOAD, 8'hFF, 1'b0);
      send_beat(FUNC_LOAD, 8'h00, 1'b0);
      send_beat(FUNC_LOAD, 8'hFF, 1'b0);
      // overlapping matches after a text restart
      send_beat(FUNC_TEXT, 8'hFF, 1'b1);
      send_beat(FUNC_TEXT, 8'h00, 1'b0);
      send_beat(FUNC_TEXT, 8'hFF, 1'b0);
      send_beat(FUNC_TEXT, 8'h00, 1'b0);
      send_beat(FUNC_TEXT, 8'hFF, 1'b0);
      // pattern restart keeps the text position
      send_beat(FUNC_LOAD, 8'h7E, 1'b1);
      send_beat(FUNC_TEXT, 8'h7E, 1'b0);
      send_beat(FUNC_TEXT, 8'h7E, 1'b0);
      // repeated symbol pattern
      send_beat(FUNC_LOAD, 8'h01, 1'b1);
      send_beat(FUNC_LOAD, 8'h01, 1'b0);
      send_beat(FUNC_TEXT, 8'h01, 1'b1);
      send_beat(FUNC_TEXT, 8'h01, 1'b0);
      send_beat(FUNC_TEXT, 8'h01, 1'b0);
      wait_drained();

      // random traffic under three backpressure mixes
      run_phase(11, 51, 1'b0);
      run_phase(51, 11, 1'b0);
      run_phase(0, 0, 1'b1);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && results_due == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/mpsm_pkg.sv
hdl/morris_pratt_stream_matcher.sv
verif/mpsm_match_checker.sv
verif/tb_morris_pratt_stream_matcher.sv
